// ===== rtl/sbrs_pkg.sv =====
`timescale 1ns / 1ps

package sbrs_pkg;

   localparam int ADDR_BITS_DEFAULT  = 48;
   localparam int MAX_PIECES_DEFAULT = 64;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [1:0] REG_BLOCK_SIZE_LOG2 = 2'd0;
   localparam logic [1:0] REG_SHARD_SIZE_LOG2 = 2'd1;
   localparam logic [1:0] REG_NUM_SHARDS      = 2'd2;

   localparam logic [4:0] BLOCK_SIZE_LOG2_RST = 5'd6;
   localparam logic [5:0] SHARD_SIZE_LOG2_RST = 6'd20;
   localparam logic [8:0] NUM_SHARDS_RST      = 9'd4;

   localparam logic [8:0] NUM_SHARDS_MAX = 9'd256;

endpackage

// ===== rtl/shard_boundary_request_splitter_unit.sv =====
// Shard boundary request splitter.
// Request channel: pulse start with req_start_address / req_size_in_bytes while
// busy is low; the word is taken at that edge. The range is cut into whole-block
// pieces, one per shard region touched, each sent to region mod num_shards.
// Result channel: each piece is one rsp_valid cycle with its fields; the receiver
// cannot stall, so pieces leave back to back, one per cycle.
// Timing: after start the region number is reduced mod num_shards by a bit-serial
// restoring divider, one bit per cycle over the ADDR_BITS-bit dividend. Pieces then
// leave from ST_EMIT through the output registers, one per cycle; busy drops in
// the cycle the last piece shows, so no new request is taken before then.
// Zero shards: one unchanged word the cycle after start, busy stays low.
// Otherwise fewer bytes than one block: no word, busy stays low.
// At most MAX_PIECES per request; with bytes left, the last carries truncated.
// CSR port: APB-style, registers at byte offsets 0, 4, 8; the user must write them
// only while idle, the block itself does not enforce it. Reset (synchronous, active
// high) returns to idle, drops rsp_valid and loads the register defaults.
`timescale 1ns / 1ps

module shard_boundary_request_splitter_unit
   import sbrs_pkg::*;
#(
   parameter int ADDR_BITS  = ADDR_BITS_DEFAULT,
   parameter int MAX_PIECES = MAX_PIECES_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  start,
   output logic                  busy,
   input  logic [ADDR_BITS-1:0]  req_start_address,
   input  logic [31:0]           req_size_in_bytes,

   output logic                  rsp_valid,
   output logic [ADDR_BITS-1:0]  rsp_piece_address,
   output logic [31:0]           rsp_piece_size,
   output logic [7:0]            rsp_target_shard,
   output logic                  rsp_last_piece,
   output logic                  rsp_truncated,

   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int BLK_W = (ADDR_BITS < 64) ? ADDR_BITS + 1 : 64;
   localparam int PW    = (MAX_PIECES > 1) ? $clog2(MAX_PIECES) : 1;
   localparam int DCW   = $clog2(ADDR_BITS + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MOD,
      ST_EMIT
   } state_type;

   state_type            state_ff, state_in;
   logic [BLK_W-1:0]     blk_ff, blk_in;
   logic [31:0]          rem_ff, rem_in;
   logic [63:0]          room_ff, room_in;
   logic [ADDR_BITS-1:0] div_ff, div_in;
   logic [DCW-1:0]       divcnt_ff, divcnt_in;
   logic [7:0]           shard_ff, shard_in;
   logic [PW-1:0]        k_ff, k_in;

   logic                 valid_ff, valid_in;
   logic [ADDR_BITS-1:0] addr_ff, addr_in;
   logic [31:0]          size_ff, size_in;
   logic [7:0]           tshard_ff, tshard_in;
   logic                 last_ff, last_in;
   logic                 trunc_ff, trunc_in;

   logic [4:0]           bsz_ff;
   logic [5:0]           ssz_ff;
   logic [8:0]           nsh_ff;

   logic                 accept;
   logic                 csr_write;
   logic [8:0]           n_eff;
   logic [5:0]           s_eff;
   logic [5:0]           rlog;
   logic [63:0]          pow;
   logic [63:0]          blk64;
   logic [31:0]          start_rem;
   logic [8:0]           trial;
   logic [8:0]           trial_red;
   logic [31:0]          cnt;
   logic [31:0]          rem_after;
   logic                 at_cap;
   logic                 fin;
   logic [8:0]           shard_inc;

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   assign n_eff     = (nsh_ff > NUM_SHARDS_MAX) ? NUM_SHARDS_MAX : nsh_ff;
   assign s_eff     = (ssz_ff < {1'b0, bsz_ff}) ? {1'b0, bsz_ff} : ssz_ff;
   assign rlog      = s_eff - {1'b0, bsz_ff};
   assign pow       = 64'(1) << rlog;
   assign blk64     = 64'(blk_ff);
   assign start_rem = req_size_in_bytes >> bsz_ff;

   // restoring mod step, one dividend bit per cycle
   assign trial     = {shard_ff, div_ff[ADDR_BITS-1]};
   assign trial_red = (trial >= n_eff) ? trial - n_eff : trial;

   assign cnt       = (64'(rem_ff) < room_ff) ? rem_ff : room_ff[31:0];
   assign rem_after = rem_ff - cnt;
   assign at_cap    = (k_ff == PW'(MAX_PIECES - 1));
   assign fin       = (rem_after == 32'd0) || at_cap;
   assign shard_inc = {1'b0, shard_ff} + 9'd1;

   always_comb begin
      state_in  = state_ff;
      blk_in    = blk_ff;
      rem_in    = rem_ff;
      room_in   = room_ff;
      div_in    = div_ff;
      divcnt_in = divcnt_ff;
      shard_in  = shard_ff;
      k_in      = k_ff;
      valid_in  = 1'b0;
      addr_in   = addr_ff;
      size_in   = size_ff;
      tshard_in = tshard_ff;
      last_in   = last_ff;
      trunc_in  = trunc_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (n_eff == 9'd0) begin
                  valid_in  = 1'b1;
                  addr_in   = req_start_address;
                  size_in   = req_size_in_bytes;
                  tshard_in = 8'd0;
                  last_in   = 1'b1;
                  trunc_in  = 1'b0;
               end else if (start_rem != 32'd0) begin
                  state_in  = ST_MOD;
                  blk_in    = BLK_W'(req_start_address >> bsz_ff);
                  rem_in    = start_rem;
                  div_in    = req_start_address >> s_eff;
                  divcnt_in = DCW'(ADDR_BITS);
                  shard_in  = 8'd0;
                  k_in      = '0;
               end
            end
         end
         ST_MOD: begin
            div_in    = div_ff << 1;
            shard_in  = trial_red[7:0];
            divcnt_in = divcnt_ff - DCW'(1);
            room_in   = pow - (blk64 & (pow - 64'd1));
            if (divcnt_ff == DCW'(1)) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            valid_in  = 1'b1;
            addr_in   = ADDR_BITS'(blk64 << bsz_ff);
            size_in   = 32'(64'(cnt) << bsz_ff);
            tshard_in = shard_ff;
            last_in   = fin;
            trunc_in  = (rem_after != 32'd0) && at_cap;
            blk_in    = blk_ff + BLK_W'(cnt);
            rem_in    = rem_after;
            room_in   = pow;
            shard_in  = (shard_inc == n_eff) ? 8'd0 : shard_inc[7:0];
            k_in      = k_ff + PW'(1);
            if (fin) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      blk_ff    <= blk_in;
      rem_ff    <= rem_in;
      room_ff   <= room_in;
      div_ff    <= div_in;
      divcnt_ff <= divcnt_in;
      shard_ff  <= shard_in;
      k_ff      <= k_in;
      addr_ff   <= addr_in;
      size_ff   <= size_in;
      tshard_ff <= tshard_in;
      last_ff   <= last_in;
      trunc_ff  <= trunc_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bsz_ff <= BLOCK_SIZE_LOG2_RST;
         ssz_ff <= SHARD_SIZE_LOG2_RST;
         nsh_ff <= NUM_SHARDS_RST;
      end else if (csr_write) begin
         case (paddr[3:2])
            REG_BLOCK_SIZE_LOG2: bsz_ff <= pwdata[4:0];
            REG_SHARD_SIZE_LOG2: ssz_ff <= pwdata[5:0];
            REG_NUM_SHARDS:      nsh_ff <= pwdata[8:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_BLOCK_SIZE_LOG2: prdata = 32'(bsz_ff);
         REG_SHARD_SIZE_LOG2: prdata = 32'(ssz_ff);
         REG_NUM_SHARDS:      prdata = 32'(nsh_ff);
         default:             prdata = 32'd0;
      endcase
   end

   assign rsp_valid         = valid_ff;
   assign rsp_piece_address = addr_ff;
   assign rsp_piece_size    = size_ff;
   assign rsp_target_shard  = tshard_ff;
   assign rsp_last_piece    = last_ff;
   assign rsp_truncated     = trunc_ff;

`ifndef SYNTHESIS
   a_no_word_in_mod: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MOD) |-> !rsp_valid)
      else $error("result word during modulo phase");

   a_trunc_on_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_truncated) |-> rsp_last_piece)
      else $error("truncated flag on a non-final word");

   a_pieces_contiguous: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last_piece) |=> rsp_valid)
      else $error("gap between pieces of one request");
`endif

endmodule

// ===== verif/tb_shard_boundary_request_splitter_unit.sv =====
`timescale 1ns / 1ps

module tb_shard_boundary_request_splitter_unit;
   import sbrs_pkg::*;

   localparam int ABITS        = ADDR_BITS_DEFAULT;
   localparam int PIECE_CAP    = MAX_PIECES_DEFAULT;
   localparam int DRAIN_CYCLES = ABITS + PIECE_CAP + 8;
   localparam int NUM_PHASES   = 7;
   localparam int RANDOM_WORDS = 52;

   typedef struct packed {
      logic [ABITS-1:0] addr;
      logic [31:0]      size;
   } request_type;

   typedef struct packed {
      logic [ABITS-1:0] addr;
      logic [31:0]      size;
      logic [7:0]       shard;
      logic             last;
      logic             trunc;
   } piece_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic             start = 1'b0;
   logic             busy;
   logic [ABITS-1:0] req_start_address = '0;
   logic [31:0]      req_size_in_bytes = '0;

   logic             rsp_valid;
   logic [ABITS-1:0] rsp_piece_address;
   logic [31:0]      rsp_piece_size;
   logic [7:0]       rsp_target_shard;
   logic             rsp_last_piece;
   logic             rsp_truncated;

   logic                  psel    = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr   = '0;
   logic [CSR_DATA_W-1:0] pwdata  = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   // local copy of the register file
   logic [4:0] blk_log2_q    = BLOCK_SIZE_LOG2_RST;
   logic [5:0] shard_log2_q  = SHARD_SIZE_LOG2_RST;
   logic [8:0] shard_count_q = NUM_SHARDS_RST;

   request_type req_items[$];
   piece_type   pieces_due[$];
   request_type nxt;
   int       items_issued = 0;
   int       items_taken  = 0;
   int       pieces_seen  = 0;
   int       errors       = 0;
   int       gap_left     = 0;
   bit       quiet        = 1'b0;
   logic     taken        = 1'b0;

   shard_boundary_request_splitter_unit #(
      .ADDR_BITS  (ABITS),
      .MAX_PIECES (PIECE_CAP)
   ) DUT (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_start_address (req_start_address),
      .req_size_in_bytes (req_size_in_bytes),
      .rsp_valid         (rsp_valid),
      .rsp_piece_address (rsp_piece_address),
      .rsp_piece_size    (rsp_piece_size),
      .rsp_target_shard  (rsp_target_shard),
      .rsp_last_piece    (rsp_last_piece),
      .rsp_truncated     (rsp_truncated),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   always #1 clock = ~clock;

   task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
      errors++;
      if (errors <= 40) begin
         $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
      end
   endtask

   // pieces that one request word should produce under the current registers
   function automatic void split_request(logic [ABITS-1:0] sa, logic [31:0] sz);
      logic [63:0] blk, left, mask, room, cnt, shards;
      int          b, s, rlog, k;
      piece_type   p;
      b = blk_log2_q;
      s = shard_log2_q;
      shards = (shard_count_q > NUM_SHARDS_MAX) ? 64'(NUM_SHARDS_MAX) : 64'(shard_count_q);
      if (shards == 0) begin
         p.addr  = sa;
         p.size  = sz;
         p.shard = 8'd0;
         p.last  = 1'b1;
         p.trunc = 1'b0;
         pieces_due.push_back(p);
         return;
      end
      if (s < b) s = b;
      rlog = s - b;
      blk  = 64'(sa) >> b;
      left = 64'(sz) >> b;
      mask = (rlog == 0) ? 64'd0 : ({64{1'b1}} >> (64 - rlog));
      k    = 0;
      while (left != 0 && k < PIECE_CAP) begin
         room = (64'd1 << rlog) - (blk & mask);
         cnt  = (left < room) ? left : room;
         left = left - cnt;
         p.addr  = ABITS'(blk << b);
         p.size  = 32'(cnt << b);
         p.shard = 8'((blk >> rlog) % shards);
         p.last  = (left == 0) || (k == PIECE_CAP - 1);
         p.trunc = (left != 0) && (k == PIECE_CAP - 1);
         pieces_due.push_back(p);
         blk = blk + cnt;
         k++;
      end
   endfunction

   function automatic request_type make_request();
      request_type r;
      logic [63:0] a, sz;
      int          b, s;
      b = blk_log2_q;
      s = (shard_log2_q < blk_log2_q) ? blk_log2_q : shard_log2_q;
      case ($urandom_range(0, 3))
         0: a = {$urandom, $urandom};
         1: a = ({$urandom, $urandom} << s) - 64'($urandom_range(0, 2 << b));
         2: a = {64{1'b1}} - 64'($urandom_range(0, 4 << b));
         default: a = 64'($urandom_range(0, 1 << 20));
      endcase
      case ($urandom_range(0, 5))
         0: sz = 64'($urandom);
         1: sz = 64'($urandom_range(0, 2 << b));
         2: sz = (64'($urandom_range(62, 66)) << s) + 64'($urandom_range(0, 1 << b));
         default: sz = (64'($urandom_range(0, 4)) << s) + 64'($urandom_range(0, 4 << b));
      endcase
      r.addr = a[ABITS-1:0];
      r.size = sz[31:0];
      return r;
   endfunction

   task automatic queue_item(logic [ABITS-1:0] a, logic [31:0] sz);
      request_type r;
      r.addr = a;
      r.size = sz;
      req_items.push_back(r);
      items_issued++;
   endtask

   task automatic write_csr(logic [1:0] idx, logic [31:0] val);
      logic [31:0] rd;
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= val;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      rd = prdata;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      if (rd !== val) flag_mismatch("register readback", rd, val);
      case (idx)
         REG_BLOCK_SIZE_LOG2: blk_log2_q    = val[4:0];
         REG_SHARD_SIZE_LOG2: shard_log2_q  = val[5:0];
         REG_NUM_SHARDS:      shard_count_q = val[8:0];
         default: ;
      endcase
   endtask

   task automatic settle();
      while (items_taken != items_issued || pieces_due.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // driver
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (start && !taken) begin
         start <= 1'b1;
      end else if (gap_left > 0) begin
         start    <= 1'b0;
         gap_left <= gap_left - 1;
      end else if (req_items.size() == 0) begin
         start <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
         start    <= 1'b0;
         gap_left <= $urandom_range(0, 14);
      end else begin
         nxt = req_items.pop_front();
         start             <= 1'b1;
         req_start_address <= nxt.addr;
         req_size_in_bytes <= nxt.size;
      end
   end

   // monitor: check pieces first, a word taken at this edge cannot have one out yet
   always @(posedge clock) begin
      piece_type want;
      taken <= !reset && start && !busy;
      if (!reset) begin
         if (rsp_valid) begin
            pieces_seen++;
            if (pieces_due.size() == 0) begin
               flag_mismatch("piece with none pending", 64'(rsp_piece_address), 64'd0);
            end else begin
               want = pieces_due.pop_front();
               if (rsp_piece_address !== want.addr)
                  flag_mismatch("piece_address", 64'(rsp_piece_address), 64'(want.addr));
               if (rsp_piece_size !== want.size)
                  flag_mismatch("piece_size", 64'(rsp_piece_size), 64'(want.size));
               if (rsp_target_shard !== want.shard)
                  flag_mismatch("target_shard", 64'(rsp_target_shard), 64'(want.shard));
               if (rsp_last_piece !== want.last)
                  flag_mismatch("last_piece", 64'(rsp_last_piece), 64'(want.last));
               if (rsp_truncated !== want.trunc)
                  flag_mismatch("truncated", 64'(rsp_truncated), 64'(want.trunc));
            end
         end
         if (start && !busy) begin
            split_request(req_start_address, req_size_in_bytes);
            items_taken++;
         end
      end
   end

   initial begin
      logic [31:0] b_val, s_val, n_val;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         if (ph > 0) begin
            settle();
            case (ph)
               1: begin b_val = 0;  s_val = 0;  n_val = 1;   end
               2: begin b_val = 16; s_val = 40; n_val = 256; end
               3: begin b_val = 5;  s_val = 9;  n_val = 0;   end
               4: begin b_val = 12; s_val = 4;  n_val = 511; end
               5: begin b_val = 3;  s_val = 8;  n_val = 300; end
               default: begin
                  b_val = $urandom_range(0, 16);
                  s_val = $urandom_range(0, 40);
                  n_val = $urandom_range(0, 256);
               end
            endcase
            write_csr(REG_BLOCK_SIZE_LOG2, b_val);
            write_csr(REG_SHARD_SIZE_LOG2, s_val);
            write_csr(REG_NUM_SHARDS, n_val);
         end
         quiet = (ph == NUM_PHASES - 1);
         @(posedge clock);
         case (ph)
            0: begin
               queue_item('0, 32'd0);
               queue_item('0, 32'd63);                       // under one block
               queue_item(48'h0_0001_2345, 32'd64);
               queue_item(48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF); // wraps, hits cap
               queue_item('0, 32'h0400_0000);                 // exactly cap, no cut
               queue_item('0, 32'h0410_0000);                 // one region over cap
               queue_item(48'h0_000F_FFC0, 32'd128);          // straddles a region edge
               queue_item(48'h0_003F_FFFF, 32'h0020_0007);
               queue_item(48'hFFFF_FFFF_FFC0, 32'h0000_0200);
               queue_item(48'hAAAA_5555_AAAA, 32'h5555_AAAA);
               queue_item(48'h5555_AAAA_5555, 32'hAAAA_5555);
               queue_item('0, 32'h8000_0000);
            end
            1: begin
               queue_item(48'hFFFF_FFFF_FFFF, 32'd1);
               queue_item('0, 32'hFFFF_FFFF);
            end
            2: begin
               queue_item(48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
               queue_item(48'h00FF_FFFF_0000, 32'h0000_FFFF);
               queue_item(48'h00FF_FFFF_0000, 32'h0002_0000);
            end
            3: begin
               queue_item('0, 32'd0);
               queue_item(48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
               queue_item(48'h1234_5678_9ABC, 32'd17);
            end
            4: begin
               queue_item(48'h0_0000_0FFF, 32'h0001_0000);
               queue_item(48'hFFFF_FFFF_F000, 32'hFFFF_FFFF);
            end
            default: ;
         endcase
         repeat (RANDOM_WORDS) begin
            nxt = make_request();
            queue_item(nxt.addr, nxt.size);
         end
      end
      settle();
      $display("%0d request words over %0d register settings, %0d pieces checked",
               items_taken, NUM_PHASES, pieces_seen);
      if (errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #600000;
      $display("simulation failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/sbrs_pkg.sv
rtl/shard_boundary_request_splitter_unit.sv
verif/tb_shard_boundary_request_splitter_unit.sv
